// File: rtl/assert_macros.svh
// Assertion macros used by the port-level checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLY(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: rtl/fssr_pkg.sv
// Shared types and constants of the filled shape span rasterizer.
// No dependencies; imported by every module of the block.
package fssr_pkg;

    localparam int COORD_BITS = 13;
    localparam int SIZE_BITS  = 5;
    localparam int ROW_BITS   = 12;
    localparam int OFS_BITS   = 26;
    localparam int PBITS_W    = 6;
    localparam int MUL_A_W    = 24;
    localparam int MUL_B_W    = 13;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 80;
    localparam logic [COORD_BITS-1:0] SCREEN_MAX = 13'd4096;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_PBITS  = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] width;
        logic [COORD_BITS-1:0] height;
        logic [PBITS_W-1:0]    pbits;
    } cfg_t;

    typedef enum logic [2:0] {
        MUL_NONE = 3'd0,
        MUL_RR   = 3'd1,
        MUL_DY   = 3'd2,
        MUL_SQ   = 3'd3,
        MUL_ROW  = 3'd4,
        MUL_PIX  = 3'd5
    } mul_op_t;

    typedef struct packed {
        logic [SIZE_BITS-1:0]  rad;
        logic [SIZE_BITS-1:0]  dy_abs;
        logic [SIZE_BITS-1:0]  trial;
        logic [ROW_BITS-1:0]   row;
        logic [COORD_BITS-1:0] width;
        logic [MUL_A_W-1:0]    pix;
        logic [PBITS_W-1:0]    pbits;
    } mul_in_t;

endpackage

// File: rtl/filled_shape_span_rasterizer.sv
// Top level of the filled shape span rasterizer: config registers, sequencer, multiplier.
// Depends on fssr_pkg, fssr_cfg, fssr_mul and fssr_seq.
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid/s_tready    s_tdata: shape geometry and color, s_tuser: kind
//  m_*       out        m_tvalid/m_tready    m_tdata: span, m_tuser: empty, m_tlast: last
//  cfg_*     in         cfg_we               cfg_index, cfg_data
//
// Each covered row runs a bitwise width search for a disc, or takes the half width for a
// rectangle; the bitwise width search and the offset products share one multiplier.
// A command with no covered row emits no span. A stalled output holds the current
// span and freezes the row walk. Reset clears the sequencer and restores 320x240, 16 bpp.
module filled_shape_span_rasterizer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [12:0] center_x, [25:13] center_y, [30:26] radius, [35:31] half_width,
    // [43:36] red, [51:44] green, [59:52] blue, [63:60] zero
    input  logic [fssr_pkg::IN_DATA_W-1:0]   s_tdata,
    // [0] kind
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [11:0] span_row, [23:12] span_start, [35:24] span_end, [61:36] span_offset,
    // [77:62] pixel_color, [79:78] zero
    output logic [fssr_pkg::OUT_DATA_W-1:0]  m_tdata,
    // [0] span_empty
    output logic                             m_tuser,
    output logic                             m_tlast,
    input  logic                             cfg_we,
    input  logic [1:0]                       cfg_index,
    input  logic [fssr_pkg::COORD_BITS-1:0]  cfg_data
);
    import fssr_pkg::*;

    cfg_t               cfg;
    mul_op_t            mul_op;
    mul_in_t            mul_in;
    logic [PROD_W-1:0]  prod;

    fssr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fssr_mul u_mul (
        .clk  (clk),
        .op   (mul_op),
        .opnd (mul_in),
        .prod (prod)
    );

    fssr_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .mul_op   (mul_op),
        .mul_in   (mul_in),
        .prod     (prod)
    );

endmodule

// File: rtl/fssr_cfg.sv
// Configuration registers with clamping of the screen size to the maximum.
// Depends on fssr_pkg.
module fssr_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [1:0]                       cfg_index,
    input  logic [fssr_pkg::COORD_BITS-1:0]  cfg_data,
    output fssr_pkg::cfg_t                   cfg
);
    import fssr_pkg::*;

    logic [COORD_BITS-1:0] width_reg, width_next;
    logic [COORD_BITS-1:0] height_reg, height_next;
    logic [PBITS_W-1:0]    pbits_reg, pbits_next;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        pbits_next  = pbits_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  width_next  = cfg_data;
                CFG_HEIGHT: height_next = cfg_data;
                CFG_PBITS:  pbits_next  = cfg_data[PBITS_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd320;
            height_reg <= 13'd240;
            pbits_reg  <= 6'd16;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            pbits_reg  <= pbits_next;
        end
    end

    assign cfg.width  = (width_reg > SCREEN_MAX) ? SCREEN_MAX : width_reg;
    assign cfg.height = (height_reg > SCREEN_MAX) ? SCREEN_MAX : height_reg;
    assign cfg.pbits  = pbits_reg;

endmodule

// File: rtl/fssr_mul.sv
// Shared multiplier: operand select by opcode and a registered product.
// Depends on fssr_pkg.
module fssr_mul (
    input  logic                         clk,
    input  fssr_pkg::mul_op_t            op,
    input  fssr_pkg::mul_in_t            opnd,
    output logic [fssr_pkg::PROD_W-1:0]  prod
);
    import fssr_pkg::*;

    logic [MUL_A_W-1:0] op_a;
    logic [MUL_B_W-1:0] op_b;
    logic [PROD_W-1:0]  prod_reg;

    always_comb
    begin
        unique case (op)
            MUL_RR:
            begin
                op_a = MUL_A_W'(opnd.rad);
                op_b = MUL_B_W'(opnd.rad) + MUL_B_W'(1);
            end
            MUL_DY:
            begin
                op_a = MUL_A_W'(opnd.dy_abs);
                op_b = MUL_B_W'(opnd.dy_abs);
            end
            MUL_SQ:
            begin
                op_a = MUL_A_W'(opnd.trial);
                op_b = MUL_B_W'(opnd.trial);
            end
            MUL_ROW:
            begin
                op_a = MUL_A_W'(opnd.row);
                op_b = opnd.width;
            end
            MUL_PIX:
            begin
                op_a = opnd.pix;
                op_b = MUL_B_W'(opnd.pbits);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

// File: rtl/fssr_seq.sv
// Sequencer: row walk, bitwise disc width search, clipping and span output register.
// Depends on fssr_pkg; drives the shared multiplier fssr_mul.
module fssr_seq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  fssr_pkg::cfg_t                    cfg,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fssr_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fssr_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast,
    output fssr_pkg::mul_op_t                 mul_op,
    output fssr_pkg::mul_in_t                 mul_in,
    input  logic [fssr_pkg::PROD_W-1:0]       prod
);
    import fssr_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_CHECK = 11'b00000000010,
        ST_RRCAP = 11'b00000000100,
        ST_ROW   = 11'b00000001000,
        ST_LIM   = 11'b00000010000,
        ST_SQ    = 11'b00000100000,
        ST_SQC   = 11'b00001000000,
        ST_CLIP  = 11'b00010000000,
        ST_PIX   = 11'b00100000000,
        ST_SCALE = 11'b01000000000,
        ST_EMIT  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic                  kind_reg, kind_next;
    logic [COORD_BITS-1:0] cx_reg, cx_next;
    logic [COORD_BITS-1:0] cy_reg, cy_next;
    logic [SIZE_BITS-1:0]  rad_reg, rad_next;
    logic [SIZE_BITS-1:0]  hw_reg, hw_next;
    logic [15:0]           color_reg, color_next;
    logic [ROW_BITS-1:0]   row_reg, row_next;
    logic [COORD_BITS-1:0] bot_reg, bot_next;
    logic [9:0]            rr_reg, rr_next;
    logic [9:0]            lim_reg, lim_next;
    logic [SIZE_BITS-1:0]  dx_reg, dx_next;
    logic [SIZE_BITS-1:0]  bit_reg, bit_next;
    logic [ROW_BITS-1:0]   left_reg, left_next;
    logic [ROW_BITS-1:0]   right_reg, right_next;
    logic                  empty_reg, empty_next;
    logic [MUL_A_W-1:0]    pix_reg, pix_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                  out_empty_reg, out_empty_next;
    logic                  out_last_reg, out_last_next;

    logic signed [13:0] cx_s, cy_s, top_s, bot_s, top_c, bot_c, h_s;
    logic signed [13:0] dy_s, dy_abs_s, left_s, right_s, left_c, right_c, wm1_s;
    logic [SIZE_BITS-1:0] trial;
    logic                 sq_ok;
    logic                 row_empty;
    logic                 last_row;
    logic                 out_free;
    logic [OFS_BITS-1:0]  offset;

    always_comb
    begin
        cx_s     = $signed({cx_reg[COORD_BITS-1], cx_reg});
        cy_s     = $signed({cy_reg[COORD_BITS-1], cy_reg});
        top_s    = cy_s - $signed({9'd0, rad_reg});
        bot_s    = cy_s + $signed({9'd0, rad_reg}) + 14'sd1;
        h_s      = $signed({1'b0, cfg.height});
        top_c    = (top_s < 14'sd0) ? 14'sd0 : top_s;
        bot_c    = (bot_s > h_s) ? h_s : bot_s;
        dy_s     = $signed({2'b00, row_reg}) - cy_s;
        dy_abs_s = (dy_s < 14'sd0) ? -dy_s : dy_s;
        trial    = dx_reg | bit_reg;
        sq_ok    = (trial <= rad_reg) && (prod[10:0] <= {1'b0, lim_reg});
        left_s   = cx_s - $signed({9'd0, dx_reg});
        right_s  = cx_s + $signed({9'd0, dx_reg});
        wm1_s    = $signed({1'b0, cfg.width}) - 14'sd1;
        left_c   = (left_s < 14'sd0) ? 14'sd0 : left_s;
        right_c  = (right_s > wm1_s) ? wm1_s : right_s;
        row_empty = left_c > right_c;
        last_row = (({1'b0, row_reg}) + 13'd1) == bot_reg;
        out_free = !out_valid_reg || m_tready;
        offset   = empty_reg ? '0 : prod[OFS_BITS+2:3];
    end

    always_comb
    begin
        mul_in.rad    = rad_reg;
        mul_in.dy_abs = dy_abs_s[SIZE_BITS-1:0];
        mul_in.trial  = trial;
        mul_in.row    = row_reg;
        mul_in.width  = cfg.width;
        mul_in.pix    = pix_reg;
        mul_in.pbits  = cfg.pbits;
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        rad_next       = rad_reg;
        hw_next        = hw_reg;
        color_next     = color_reg;
        row_next       = row_reg;
        bot_next       = bot_reg;
        rr_next        = rr_reg;
        lim_next       = lim_reg;
        dx_next        = dx_reg;
        bit_next       = bit_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        empty_next     = empty_reg;
        pix_next       = pix_reg;
        out_data_next  = out_data_reg;
        out_empty_next = out_empty_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        mul_op         = MUL_NONE;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next  = s_tuser;
                    cx_next    = s_tdata[12:0];
                    cy_next    = s_tdata[25:13];
                    rad_next   = s_tdata[30:26];
                    hw_next    = s_tdata[35:31];
                    color_next = {s_tdata[43:39], s_tdata[51:46], s_tdata[59:55]};
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                row_next = top_c[ROW_BITS-1:0];
                bot_next = bot_c[COORD_BITS-1:0];
                mul_op   = MUL_RR;
                state_next = (top_c >= bot_c) ? ST_IDLE : ST_RRCAP;
            end
            ST_RRCAP:
            begin
                rr_next    = prod[9:0];
                mul_op     = MUL_DY;
                state_next = ST_LIM;
            end
            ST_ROW:
            begin
                mul_op     = MUL_DY;
                state_next = ST_LIM;
            end
            ST_LIM:
            begin
                lim_next = rr_reg - prod[9:0];
                if (kind_reg)
                begin
                    dx_next    = '0;
                    bit_next   = 5'b10000;
                    state_next = ST_SQ;
                end
                else
                begin
                    dx_next    = hw_reg;
                    state_next = ST_CLIP;
                end
            end
            ST_SQ:
            begin
                mul_op     = MUL_SQ;
                state_next = ST_SQC;
            end
            ST_SQC:
            begin
                if (sq_ok)
                begin
                    dx_next = trial;
                end
                bit_next   = bit_reg >> 1;
                state_next = bit_reg[0] ? ST_CLIP : ST_SQ;
            end
            ST_CLIP:
            begin
                empty_next = row_empty;
                left_next  = row_empty ? '0 : left_c[ROW_BITS-1:0];
                right_next = row_empty ? '0 : right_c[ROW_BITS-1:0];
                mul_op     = MUL_ROW;
                state_next = ST_PIX;
            end
            ST_PIX:
            begin
                pix_next   = prod[MUL_A_W-1:0] + MUL_A_W'(left_reg);
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                mul_op     = MUL_PIX;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                mul_op = MUL_PIX;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {2'b00, color_reg, offset, right_reg, left_reg, row_reg};
                    out_empty_next = empty_reg;
                    out_last_next  = last_row;
                    if (last_row)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg + 12'd1;
                        state_next = ST_ROW;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        rad_reg       <= rad_next;
        hw_reg        <= hw_next;
        color_reg     <= color_next;
        row_reg       <= row_next;
        bot_reg       <= bot_next;
        rr_reg        <= rr_next;
        lim_reg       <= lim_next;
        dx_reg        <= dx_next;
        bit_reg       <= bit_next;
        left_reg      <= left_next;
        right_reg     <= right_next;
        empty_reg     <= empty_next;
        pix_reg       <= pix_next;
        out_data_reg  <= out_data_next;
        out_empty_reg <= out_empty_next;
        out_last_reg  <= out_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_empty_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: rtl/fssr_checker.sv
// Port-level checks of the span rasterizer, bound to the top level.
// Depends on fssr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fssr_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [fssr_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic                             m_tuser,
    input logic                             m_tlast
);
    import fssr_pkg::*;

    `ASSERT_NEXT(busy_after_request, clk, rst_n, s_tvalid && s_tready, !s_tready, "ready after request")
    `ASSERT_IMPLY(empty_span_zero, clk, rst_n, m_tvalid && m_tuser, m_tdata[61:12] == 50'd0, "empty span not zero")
    `ASSERT_IMPLY(span_ordered, clk, rst_n, m_tvalid && !m_tuser, m_tdata[23:12] <= m_tdata[35:24], "start after end")
    `ASSERT_NEXT(stall_holds, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled span changed")

endmodule

bind filled_shape_span_rasterizer fssr_checker u_fssr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// File: bench/fssr_tb_pkg.sv
// Shape codes shared by the span checker and the testbench top.
// No dependencies; compile before the other bench files.
package fssr_tb_pkg;

    localparam logic SHAPE_RECT = 1'b0;
    localparam logic SHAPE_DISC = 1'b1;

endpackage

// File: bench/fssr_span_checker.sv
// Span checker: mirrors the screen registers, works out the spans of every accepted
// draw request and compares them field by field with the output stream.
// Depends on fssr_pkg and fssr_tb_pkg.
module fssr_span_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [fssr_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [fssr_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                            m_tuser,
    input  logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [fssr_pkg::COORD_BITS-1:0] cfg_data,
    output int                              mismatches,
    output int                              outstanding
);
    import fssr_pkg::*;
    import fssr_tb_pkg::*;

    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [ROW_BITS-1:0] first_col;
        logic [ROW_BITS-1:0] last_col;
        logic                empty;
        logic [OFS_BITS-1:0] offset;
        logic [15:0]         color;
        logic                last;
    } span_t;

    span_t                 span_q[$];
    logic [COORD_BITS-1:0] scr_width;
    logic [COORD_BITS-1:0] scr_height;
    logic [PBITS_W-1:0]    scr_pbits;

    function automatic void rasterize_request(input logic kind,
                                              input logic [IN_DATA_W-1:0] data);
        int              cx;
        int              cy;
        int              rad;
        int              hw;
        int              w;
        int              h;
        int              top_row;
        int              stop_row;
        int              row;
        int              dy;
        int              lim;
        int              dx;
        int              left_col;
        int              right_col;
        longint unsigned pix;
        span_t           sp;
        cx = int'($signed(data[12:0]));
        cy = int'($signed(data[25:13]));
        rad = int'(data[30:26]);
        hw = int'(data[35:31]);
        w = int'((scr_width > SCREEN_MAX) ? SCREEN_MAX : scr_width);
        h = int'((scr_height > SCREEN_MAX) ? SCREEN_MAX : scr_height);
        top_row = (cy - rad < 0) ? 0 : cy - rad;
        stop_row = (cy + rad + 1 > h) ? h : cy + rad + 1;
        for (row = top_row; row < stop_row; row++)
        begin
            dy = row - cy;
            if (kind == SHAPE_DISC)
            begin
                lim = rad * (rad + 1) - dy * dy;
                dx = rad;
                while (dx > 0 && dx * dx > lim)
                    dx--;
            end
            else
                dx = hw;
            left_col = (cx - dx < 0) ? 0 : cx - dx;
            right_col = (cx + dx > w - 1) ? w - 1 : cx + dx;
            sp = '0;
            sp.row = 12'(row);
            sp.color = {data[43:39], data[51:46], data[59:55]};
            sp.last = (row == stop_row - 1);
            if (left_col > right_col)
                sp.empty = 1'b1;
            else
            begin
                pix = 64'(row * w + left_col);
                pix = (pix * scr_pbits) / 8;
                sp.first_col = 12'(left_col);
                sp.last_col = 12'(right_col);
                sp.offset = 26'(pix);
            end
            span_q.push_back(sp);
        end
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $realtime, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        span_t want;
        span_t got;
        if (!rst_n)
        begin
            scr_width <= 13'd320;
            scr_height <= 13'd240;
            scr_pbits <= 6'd16;
            span_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_WIDTH:  scr_width <= cfg_data;
                    CFG_HEIGHT: scr_height <= cfg_data;
                    CFG_PBITS:  scr_pbits <= cfg_data[PBITS_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                rasterize_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
            begin
                got.row = m_tdata[11:0];
                got.first_col = m_tdata[23:12];
                got.last_col = m_tdata[35:24];
                got.offset = m_tdata[61:36];
                got.color = m_tdata[77:62];
                got.empty = m_tuser;
                got.last = m_tlast;
                if (span_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: span row 0x%0h with none expected, got 0x%0h",
                             $realtime, got.row, got);
                end
                else
                begin
                    want = span_q.pop_front();
                    check_field("span_row", want.row, got.row);
                    check_field("span_start", want.first_col, got.first_col);
                    check_field("span_end", want.last_col, got.last_col);
                    check_field("span_empty", want.empty, got.empty);
                    check_field("span_offset", want.offset, got.offset);
                    check_field("pixel_color", want.color, got.color);
                    check_field("last_span", want.last, got.last);
                end
            end
            outstanding <= span_q.size();
        end
    end

endmodule

// File: bench/tb_filled_shape_span_rasterizer.sv
// Testbench top for the filled shape span rasterizer: clock, reset, screen setup,
// draw request stimulus, output stalls, watchdog and verdict.
// Depends on fssr_pkg, fssr_tb_pkg, fssr_span_checker and the rasterizer RTL.
module tb_filled_shape_span_rasterizer;
    import fssr_pkg::*;
    import fssr_tb_pkg::*;

    localparam int IDLE_LIMIT    = 5000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 20;

    typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_mode_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_we = 1'b0;
    logic [1:0]            cfg_index = '0;
    logic [COORD_BITS-1:0] cfg_data = '0;
    int                    mismatches;
    int                    outstanding;
    int                    idle_cycles;
    int                    hold_asked;

    filled_shape_span_rasterizer u_dut (.*);

    fssr_span_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_draw(input logic kind, input logic [12:0] cx, input logic [12:0] cy,
                             input logic [4:0] rad, input logic [4:0] hw,
                             input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue);
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {4'b0, blue, green, red, hw, rad, cy, cx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic set_screen(input logic [12:0] w, input logic [12:0] h,
                              input logic [5:0] pbits);
        cfg_we <= 1'b1;
        cfg_index <= CFG_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_index <= CFG_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_index <= CFG_PBITS;
        cfg_data <= {7'b0, pbits};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain_spans();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_draws(input int n_items, input int w, input int h);
        int          sent;
        int          burst;
        int          gap;
        logic [12:0] cx;
        logic [12:0] cy;
        logic [4:0]  rad;
        sent = 0;
        while (sent < n_items)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    cx = 13'($urandom);
                    cy = 13'($urandom);
                end
                else
                begin
                    cx = 13'(int'($urandom_range(0, w + 80)) - 40);
                    cy = 13'(int'($urandom_range(0, h + 80)) - 40);
                end
                rad = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 2)) : 5'($urandom);
                send_draw(1'($urandom), cx, cy, rad, 5'($urandom), 8'($urandom),
                          8'($urandom), 8'($urandom));
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // output side stall pattern, with one long hold when asked
    initial
    begin
        int       seg_len;
        int       hold_served;
        rx_mode_t mode;
        hold_served = 0;
        wait (rst_n);
        forever
        begin
            seg_len = $urandom_range(10, 120);
            mode = rx_mode_t'($urandom_range(0, 3));
            repeat (seg_len)
            begin
                if (hold_asked != hold_served)
                begin
                    hold_served++;
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                case (mode)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
                    RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= ~m_tready;
                endcase
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** filled_shape_span_rasterizer: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int w;
        int h;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset screen: 320x240, 16 bpp
        send_draw(SHAPE_RECT, 13'd160, 13'd120, 5'd0, 5'd0, 8'h00, 8'h00, 8'h00);
        send_draw(SHAPE_RECT, 13'd160, 13'd120, 5'd31, 5'd31, 8'hFF, 8'hFF, 8'hFF);
        send_draw(SHAPE_DISC, 13'd160, 13'd120, 5'd0, 5'd0, 8'hAA, 8'h55, 8'hAA);
        send_draw(SHAPE_DISC, 13'd160, 13'd120, 5'd1, 5'd31, 8'h55, 8'hAA, 8'h55);
        send_draw(SHAPE_DISC, 13'd160, 13'd120, 5'd31, 5'd0, 8'h0F, 8'hF0, 8'h88);
        send_draw(SHAPE_RECT, 13'd100, -13'sd100, 5'd31, 5'd31, 8'h12, 8'h34, 8'h56);
        send_draw(SHAPE_DISC, 13'd100, 13'd300, 5'd31, 5'd3, 8'h78, 8'h9A, 8'hBC);
        send_draw(SHAPE_RECT, -13'sd100, 13'd50, 5'd4, 5'd31, 8'hDE, 8'hF0, 8'h01);
        send_draw(SHAPE_DISC, 13'd400, 13'd50, 5'd20, 5'd7, 8'h80, 8'h40, 8'h20);
        send_draw(SHAPE_DISC, 13'd0, 13'd0, 5'd31, 5'd0, 8'hFF, 8'h00, 8'hFF);
        send_draw(SHAPE_RECT, 13'd319, 13'd239, 5'd31, 5'd31, 8'h00, 8'hFF, 8'h00);
        send_draw(SHAPE_RECT, 13'h1000, 13'h1000, 5'd31, 5'd31, 8'h11, 8'h22, 8'h33);
        send_draw(SHAPE_DISC, 13'h0FFF, 13'h0FFF, 5'd31, 5'd31, 8'h44, 8'h55, 8'h66);
        send_draw(SHAPE_RECT, 13'd5, 13'd239, 5'd3, 5'd31, 8'h77, 8'h88, 8'h99);
        send_draw(SHAPE_DISC, 13'd200, -13'sd31, 5'd31, 5'd0, 8'hC3, 8'h3C, 8'h5A);
        drain_spans();

        set_screen(13'd4096, 13'd4096, 6'd32);
        send_draw(SHAPE_RECT, 13'd4095, 13'd4095, 5'd31, 5'd31, 8'hFF, 8'hFF, 8'hFF);
        send_draw(SHAPE_DISC, 13'd4064, 13'd4064, 5'd31, 5'd0, 8'h01, 8'h02, 8'h03);
        send_draw(SHAPE_RECT, 13'd0, 13'd0, 5'd31, 5'd31, 8'hFE, 8'hFD, 8'hFC);
        random_draws(30, 4096, 4096);
        drain_spans();

        set_screen(13'd1, 13'd1, 6'd8);
        send_draw(SHAPE_DISC, 13'd0, 13'd0, 5'd31, 5'd31, 8'hA5, 8'h5A, 8'hA5);
        send_draw(SHAPE_RECT, 13'd0, 13'd0, 5'd0, 5'd0, 8'h5A, 8'hA5, 8'h5A);
        random_draws(20, 1, 1);
        drain_spans();

        // oversized screen registers clip at 4096
        set_screen(13'h1FFF, 13'h1FFF, 6'd12);
        send_draw(SHAPE_RECT, 13'd4090, 13'd4090, 5'd10, 5'd10, 8'h3C, 8'hC3, 8'h99);
        random_draws(30, 4096, 4096);
        drain_spans();

        set_screen(13'd0, 13'd240, 6'd16);
        send_draw(SHAPE_RECT, 13'd10, 13'd10, 5'd3, 5'd3, 8'hFF, 8'h80, 8'h00);
        random_draws(15, 0, 240);
        drain_spans();

        set_screen(13'd320, 13'd0, 6'd16);
        send_draw(SHAPE_DISC, 13'd10, 13'd10, 5'd5, 5'd5, 8'h00, 8'h80, 8'hFF);
        random_draws(10, 320, 0);
        drain_spans();

        // hold the output for a long stretch while requests keep coming
        set_screen(13'd640, 13'd480, 6'd24);
        hold_asked <= hold_asked + 1;
        random_draws(60, 640, 480);
        drain_spans();

        set_screen(13'd320, 13'd240, 6'd16);
        random_draws(50, 320, 240);
        drain_spans();

        repeat (2)
        begin
            w = $urandom_range(1, 4096);
            h = $urandom_range(1, 4096);
            set_screen(13'(w), 13'(h), 6'($urandom_range(8, 32)));
            random_draws(40, w, h);
            drain_spans();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("** filled_shape_span_rasterizer: PASSED **");
        else
            $display("** filled_shape_span_rasterizer: FAILED **");
        $finish;
    end

endmodule

// File: filled_shape_span_rasterizer.f
+incdir+rtl
rtl/fssr_pkg.sv
rtl/fssr_cfg.sv
rtl/fssr_mul.sv
rtl/fssr_seq.sv
rtl/filled_shape_span_rasterizer.sv
rtl/fssr_checker.sv
bench/fssr_tb_pkg.sv
bench/fssr_span_checker.sv
bench/tb_filled_shape_span_rasterizer.sv
